// File: design/wmc_pkg.sv
package wmc_pkg;

	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 5;
	localparam int POS_W       = 32;
	localparam int CFG_W       = 64;
	localparam int REG_IDX_W   = 2;
	localparam int QUERY_CHARS = 16;
	localparam int QIDX_W      = 4;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_QUERY_LOW  = 2'd0,
		REG_QUERY_HIGH = 2'd1,
		REG_QUERY_LEN  = 2'd2,
		REG_MAX_MISM   = 2'd3
	} wmc_reg_t;

	// Running state of one window as it walks down the scoring chain.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] cnt;
		logic [LEN_W-1:0] mism;
	} wmc_item_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] score;
	} wmc_result_t;

endpackage

// File: design/wmc_tap_cell.sv
module wmc_tap_cell (
	input  logic                      clk,
	input  logic                      en,
	input  logic [wmc_pkg::CHAR_W-1:0] d,
	input  logic [wmc_pkg::CHAR_W-1:0] qchar,
	output logic [wmc_pkg::CHAR_W-1:0] q,
	output logic                      mismatch
);
	import wmc_pkg::*;

	logic [CHAR_W-1:0] char_q;

	always_ff @(posedge clk) begin
		if (en) begin
			char_q <= d;
		end
	end

	// The flag describes the window as it stands after this shift.
	assign mismatch = (d != qchar);
	assign q        = char_q;

endmodule

// File: design/wmc_score_cell.sv
module wmc_score_cell #(
	parameter int MAX_QUERY = 16,
	parameter int SLOT      = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [wmc_pkg::LEN_W-1:0] qlen,
	input  logic [wmc_pkg::LEN_W-1:0] limit,
	input  logic                      in_valid,
	input  wmc_pkg::wmc_item_t        in_item,
	input  logic [MAX_QUERY-1:0]      in_flags,
	output logic                      out_valid,
	output wmc_pkg::wmc_item_t        out_item,
	output logic [MAX_QUERY-1:0]      out_flags
);
	import wmc_pkg::*;

	localparam logic [LEN_W-1:0] SLOT_L = LEN_W'(SLOT);

	logic      valid_q;
	wmc_item_t item_q;
	logic [MAX_QUERY-1:0] flags_q;
	logic      go;
	wmc_item_t item_d;

	// Slots beyond the query length pass through untouched; counting stops
	// once the mismatch count has gone past the limit.
	always_comb begin
		item_d = in_item;
		go     = (SLOT_L < qlen) && (in_item.mism <= limit);
		if (go) begin
			item_d.cnt  = LEN_W'(in_item.cnt + LEN_W'(1));
			item_d.mism = LEN_W'(in_item.mism + LEN_W'(in_flags[SLOT]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q  <= item_d;
			flags_q <= in_flags;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;
	assign out_flags = flags_q;

endmodule

// File: design/windowed_mismatch_cutoff_matcher.sv
// Scores a configured query of up to MAX_QUERY characters against every window
// of a character stream.
// Input channel s_*: one character per transaction in s_tdata, with s_tuser set
// on the first character of a new region (window fill and position cleared).
// Output channel m_*: one transaction per completed window, carrying the match
// count before the mismatch cutoff and the window start position.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr;
// write only while no characters are in flight.
// Throughput is one character per cycle while the skid entry is empty. The window
// is a row of shift cells and the count walks a chain of MAX_QUERY scoring cells,
// one query position per cell; the first cell loads on the accepting edge, and the
// result passes the remaining cells and the output register before m_tvalid rises.
// When m_tready is low while a result waits, the next result to leave the chain
// moves into a skid entry; s_tready then drops and the whole chain freezes until
// m_tready takes the waiting result and the skid entry moves up.
// Reset clears the fill count, position, pipeline and output valids, and loads
// the register defaults (query length 12, mismatch limit 2, query zero).
module windowed_mismatch_cutoff_matcher #(
	parameter int MAX_QUERY = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [wmc_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] base_char
	input  logic [0:0]                       s_tuser,  // [0] restart
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [wmc_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [4:0] score, [36:5] window_position
	input  logic                             cfg_we,
	input  logic [wmc_pkg::REG_IDX_W-1:0]    cfg_addr,
	input  logic [wmc_pkg::CFG_W-1:0]        cfg_wdata
);
	import wmc_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_QUERY);

	logic [CFG_W-1:0] qlow_q;
	logic [CFG_W-1:0] qhigh_q;
	logic [LEN_W-1:0] qlen_q;
	logic [LEN_W-1:0] limit_q;
	logic [LEN_W-1:0] fill_q;
	logic [POS_W-1:0] pos_q;

	logic [LEN_W-1:0] qlen_eff;
	logic [2*CFG_W-1:0] query_all;
	logic             advance;
	logic             in_fire;
	logic             restart;
	logic [LEN_W-1:0] fill_base;
	logic [LEN_W-1:0] fill_new;
	logic             emit;
	logic [POS_W-1:0] pos_base;

	logic [CHAR_W-1:0]    win [MAX_QUERY];
	logic [CHAR_W-1:0]    qsel [MAX_QUERY];
	logic [MAX_QUERY-1:0] flags;

	logic                 cv [MAX_QUERY+1];
	wmc_item_t            ci [MAX_QUERY+1];
	logic [MAX_QUERY-1:0] cf [MAX_QUERY+1];

	logic        out_valid_q;
	wmc_result_t out_q;
	logic        skid_valid_q;
	wmc_result_t skid_q;
	logic        leave_v;
	wmc_result_t leave_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlow_q  <= '0;
			qhigh_q <= '0;
			qlen_q  <= LEN_W'(12);
			limit_q <= LEN_W'(2);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_QUERY_LOW:  qlow_q  <= cfg_wdata;
				REG_QUERY_HIGH: qhigh_q <= cfg_wdata;
				REG_QUERY_LEN:  qlen_q  <= cfg_wdata[LEN_W-1:0];
				REG_MAX_MISM:   limit_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		qlen_eff = qlen_q;
		if (qlen_q == '0) begin
			qlen_eff = LEN_W'(1);
		end else if (qlen_q > MAX_LEN) begin
			qlen_eff = MAX_LEN;
		end
	end

	assign query_all = {qhigh_q, qlow_q};

	// Front end: fill count, position and the start of a new item.
	assign advance   = !skid_valid_q;
	assign s_tready  = advance;
	assign in_fire   = s_tvalid && s_tready;
	assign restart   = s_tuser[0];
	assign fill_base = restart ? '0 : fill_q;
	assign fill_new  = (fill_base < MAX_LEN) ? LEN_W'(fill_base + LEN_W'(1)) : fill_base;
	assign emit      = (fill_new >= qlen_eff);
	assign pos_base  = restart ? '0 : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (in_fire) begin
			fill_q <= fill_new;
			pos_q  <= emit ? POS_W'(pos_base + POS_W'(1)) : pos_base;
		end
	end

	// Window slot s holds the character s places behind the newest one and
	// lines up with query character qlen - 1 - s.
	for (genvar s = 0; s < MAX_QUERY; s++) begin : g_tap
		logic [QIDX_W-1:0] qidx;
		assign qidx    = QIDX_W'(qlen_eff - LEN_W'(1) - LEN_W'(s));
		assign qsel[s] = query_all[qidx*CHAR_W +: CHAR_W];
		if (s == 0) begin : g_head
			wmc_tap_cell u_tap (
				.clk      (clk),
				.en       (in_fire),
				.d        (s_tdata[CHAR_W-1:0]),
				.qchar    (qsel[s]),
				.q        (win[s]),
				.mismatch (flags[s])
			);
		end else begin : g_body
			wmc_tap_cell u_tap (
				.clk      (clk),
				.en       (in_fire),
				.d        (win[s-1]),
				.qchar    (qsel[s]),
				.q        (win[s]),
				.mismatch (flags[s])
			);
		end
	end

	assign cv[0]      = in_fire && emit;
	assign ci[0].pos  = pos_base;
	assign ci[0].cnt  = '0;
	assign ci[0].mism = '0;
	assign cf[0]      = flags;

	// Scoring chain: cell k takes slot MAX_QUERY - 1 - k, so the oldest
	// character of the window is compared first.
	for (genvar k = 0; k < MAX_QUERY; k++) begin : g_score
		wmc_score_cell #(
			.MAX_QUERY (MAX_QUERY),
			.SLOT      (MAX_QUERY - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.qlen      (qlen_eff),
			.limit     (limit_q),
			.in_valid  (cv[k]),
			.in_item   (ci[k]),
			.in_flags  (cf[k]),
			.out_valid (cv[k+1]),
			.out_item  (ci[k+1]),
			.out_flags (cf[k+1])
		);
	end

	assign leave_v          = cv[MAX_QUERY] && advance;
	assign leave_data.pos   = ci[MAX_QUERY].pos;
	assign leave_data.score = LEN_W'(ci[MAX_QUERY].cnt - ci[MAX_QUERY].mism);

	// Output register with one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= leave_v;
			end
		end else if (leave_v) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : leave_data;
		end else if (leave_v) begin
			skid_q <= leave_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_q.pos, out_q.score});

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a pending output");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid entry loaded while the output was free");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_LEN)
		else $error("fill count beyond window depth");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.score <= MAX_LEN))
		else $error("score beyond window depth");

endmodule
